/* hw/rtl/hufd_pkg.sv */
// Shared types and constants for the Huffman tree byte decoder.
// No dependencies; every other RTL file except hufd_ram refers to this package by scoped name.
`default_nettype none

package hufd_pkg;

  localparam int TREE_NODES  = 255;
  localparam int LENGTH_BITS = 24;

  localparam int CMD_W    = 2;
  localparam int NODE_W   = 8;
  localparam int CHILD_W  = 9;
  localparam int ENTRY_W  = 2 * CHILD_W;
  localparam int EXPLEN_W = 24;
  localparam int LEN_EXT_W = 32;
  localparam int BYTE_W   = 8;
  localparam int BIT_IDX_W = $clog2(BYTE_W);
  localparam int NODE_AW  = $clog2(TREE_NODES);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [NODE_W-1:0]    NODE_LIMIT = NODE_W'(TREE_NODES);
  localparam logic [NODE_AW-1:0]   ROOT_NODE  = NODE_AW'(TREE_NODES - 1);
  localparam logic [BIT_IDX_W-1:0] BIT_LAST   = BIT_IDX_W'(BYTE_W - 1);

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_DATA  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [NODE_W-1:0]   node_index;
    logic [CHILD_W-1:0]  child_zero;
    logic [CHILD_W-1:0]  child_one;
    logic [EXPLEN_W-1:0] expand_length;
    logic [BYTE_W-1:0]   data_byte;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] symbol;
    logic              last;
    logic              done_res;
  } out_t;

  // classified work item passed from front to back
  typedef struct packed {
    kind_t                  kind;
    logic [NODE_AW-1:0]     node;
    logic [ENTRY_W-1:0]     entry;
    logic [LENGTH_BITS-1:0] len;
    logic [BYTE_W-1:0]      data;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/hufd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hufd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/hufd_front.sv */
// Front end: accepts input transactions, drops unused commands and out-of-range loads, classifies into work items.
// Depends on hufd_pkg.
`default_nettype none

module hufd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire hufd_pkg::in_t   in_data,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output hufd_pkg::item_t      push_item
);

  logic                       keep;
  hufd_pkg::item_t            item;
  logic [hufd_pkg::LEN_EXT_W-1:0] len_ext;
  logic                       fr_v_r, fr_v_nxt;
  hufd_pkg::item_t            fr_item_r;

  assign len_ext = hufd_pkg::LEN_EXT_W'(in_data.expand_length);

  always_comb begin
    keep       = 1'b0;
    item.kind  = hufd_pkg::KIND_DATA;
    item.node  = in_data.node_index[hufd_pkg::NODE_AW-1:0];
    item.entry = {in_data.child_one, in_data.child_zero};
    item.len   = len_ext[hufd_pkg::LENGTH_BITS-1:0];
    item.data  = in_data.data_byte;
    case (in_data.cmd)
      hufd_pkg::CMD_LOAD: begin
        item.kind = hufd_pkg::KIND_LOAD;
        keep      = in_data.node_index < hufd_pkg::NODE_LIMIT;
      end
      hufd_pkg::CMD_START: begin
        item.kind = hufd_pkg::KIND_START;
        keep      = 1'b1;
      end
      hufd_pkg::CMD_DATA: begin
        item.kind = hufd_pkg::KIND_DATA;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready   = !fr_v_r || push_ready;
  assign push_valid = fr_v_r;
  assign push_item  = fr_item_r;

  always_comb begin
    fr_v_nxt = fr_v_r;
    if (in_ready) begin
      fr_v_nxt = in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      fr_item_r <= item;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hufd_queue.sv */
// Short work-item queue between front and back.
// Depends on hufd_pkg.
`default_nettype none

module hufd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire hufd_pkg::item_t push_item,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output hufd_pkg::item_t      pop_item
);

  hufd_pkg::item_t                mem_r [hufd_pkg::QDEPTH];
  logic [hufd_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [hufd_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [hufd_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign push_ready = cnt_r != hufd_pkg::QCNT_W'(hufd_pkg::QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == hufd_pkg::QPTR_W'(hufd_pkg::QDEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == hufd_pkg::QPTR_W'(hufd_pkg::QDEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hufd_back.sv */
// Back end: tree memory, bit-serial tree walk, symbol hold-back and output register.
// Depends on hufd_pkg and hufd_ram.
`default_nettype none

module hufd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire hufd_pkg::item_t pop_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output hufd_pkg::out_t       out_data
);

  hufd_pkg::state_t                   state_r, state_nxt;
  logic [hufd_pkg::NODE_AW-1:0]       cur_r, cur_nxt;
  logic [hufd_pkg::LENGTH_BITS-1:0]   left_r, left_nxt, left_dec;
  logic [hufd_pkg::BYTE_W-1:0]        byte_r, byte_nxt;
  logic [hufd_pkg::BIT_IDX_W-1:0]     bit_r, bit_nxt;
  logic                               pend_v_r, pend_v_nxt;
  logic [hufd_pkg::BYTE_W-1:0]        pend_sym_r, pend_sym_nxt;
  logic                               pend_done_r, pend_done_nxt;
  logic                               stale_r;
  logic                               out_v_r, out_v_nxt;
  hufd_pkg::out_t                     out_q_r, out_q_nxt;

  logic                               we;
  logic [hufd_pkg::NODE_AW-1:0]       raddr;
  logic [hufd_pkg::ENTRY_W-1:0]       rdata;

  logic [hufd_pkg::CHILD_W-1:0]       child;
  logic                               leaf, ptr_ok, slot_free, step, end_byte;
  logic                               flush_go, pop, emit;
  logic [hufd_pkg::NODE_AW-1:0]       next_node;

  hufd_ram #(
    .WIDTH (hufd_pkg::ENTRY_W),
    .DEPTH (hufd_pkg::TREE_NODES)
  ) u_tree (
    .clk   (clk),
    .we    (we),
    .waddr (pop_item.node),
    .wdata (pop_item.entry),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign slot_free = !out_v_r || out_ready;
  assign child     = byte_r[bit_r] ? rdata[hufd_pkg::ENTRY_W-1:hufd_pkg::CHILD_W]
                                   : rdata[hufd_pkg::CHILD_W-1:0];
  assign leaf      = !child[hufd_pkg::CHILD_W-1];
  assign ptr_ok    = child[hufd_pkg::NODE_W-1:0] < hufd_pkg::NODE_LIMIT;
  assign next_node = (leaf || !ptr_ok) ? hufd_pkg::ROOT_NODE
                                       : child[hufd_pkg::NODE_AW-1:0];
  assign left_dec  = left_r - 1'b1;
  assign step      = (state_r == hufd_pkg::ST_WALK) && (!(leaf && pend_v_r) || slot_free);
  assign end_byte  = (bit_r == hufd_pkg::BIT_LAST) || (leaf && left_dec == '0);
  assign flush_go  = (state_r == hufd_pkg::ST_FLUSH) && (!pend_v_r || slot_free);
  assign pop_ready = ((state_r == hufd_pkg::ST_IDLE) || flush_go) && !stale_r;
  assign pop       = pop_ready && pop_valid;
  assign we        = pop && (pop_item.kind == hufd_pkg::KIND_LOAD);

  always_comb begin
    raddr = cur_r;
    if (step) begin
      raddr = next_node;
    end else if (pop && pop_item.kind == hufd_pkg::KIND_START) begin
      raddr = hufd_pkg::ROOT_NODE;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    left_nxt      = left_r;
    byte_nxt      = byte_r;
    bit_nxt       = bit_r;
    pend_v_nxt    = pend_v_r;
    pend_sym_nxt  = pend_sym_r;
    pend_done_nxt = pend_done_r;
    emit          = 1'b0;
    out_q_nxt     = out_q_r;

    if (step) begin
      cur_nxt = next_node;
      if (leaf) begin
        left_nxt      = left_dec;
        pend_v_nxt    = 1'b1;
        pend_sym_nxt  = child[hufd_pkg::BYTE_W-1:0];
        pend_done_nxt = left_dec == '0;
        if (pend_v_r) begin
          emit      = 1'b1;
          out_q_nxt = '{symbol: pend_sym_r, last: 1'b0, done_res: pend_done_r};
        end
      end
      if (end_byte) begin
        state_nxt = hufd_pkg::ST_FLUSH;
      end else begin
        bit_nxt = bit_r + 1'b1;
      end
    end

    if (flush_go) begin
      state_nxt = hufd_pkg::ST_IDLE;
      if (pend_v_r) begin
        emit       = 1'b1;
        out_q_nxt  = '{symbol: pend_sym_r, last: 1'b1, done_res: pend_done_r};
        pend_v_nxt = 1'b0;
      end
    end

    if (pop) begin
      case (pop_item.kind)
        hufd_pkg::KIND_START: begin
          left_nxt = pop_item.len;
          cur_nxt  = hufd_pkg::ROOT_NODE;
        end
        hufd_pkg::KIND_DATA: begin
          if (left_r != '0) begin
            state_nxt = hufd_pkg::ST_WALK;
            byte_nxt  = pop_item.data;
            bit_nxt   = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (emit) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= hufd_pkg::ST_IDLE;
      cur_r    <= hufd_pkg::ROOT_NODE;
      left_r   <= '0;
      pend_v_r <= 1'b0;
      stale_r  <= 1'b1;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      left_r   <= left_nxt;
      pend_v_r <= pend_v_nxt;
      stale_r  <= we;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    bit_r       <= bit_nxt;
    pend_sym_r  <= pend_sym_nxt;
    pend_done_r <= pend_done_nxt;
    if (emit) begin
      out_q_r <= out_q_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/huffman_tree_byte_decoder.sv */
// Top level of the Huffman tree byte decoder: front end, work queue, back end.
// Depends on hufd_pkg, hufd_front, hufd_queue, hufd_back.
//
//   port group  direction  handshake             payload
//   in_*        input      in_valid / in_ready   hufd_pkg::in_t
//   out_*       output     out_valid / out_ready hufd_pkg::out_t
//
// A data byte walks the tree one bit per cycle (one tree RAM read per bit) while
// the output is not stalled. Its last symbol is handed off in the flush state;
// the next transaction is taken in that same cycle.
// Any item right after a load is held back by stale_r so the tree RAM read can settle.
// Synchronous reset; the tree RAM is not cleared. A stalled output holds the walk.
`default_nettype none

module huffman_tree_byte_decoder (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire hufd_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output hufd_pkg::out_t      out_data
);

  logic            push_valid, push_ready;
  hufd_pkg::item_t push_item;
  logic            pop_valid, pop_ready;
  hufd_pkg::item_t pop_item;

  hufd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  hufd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  hufd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* hw/rtl/hufd_checker.sv */
// Port-level assertions for the Huffman tree byte decoder, bound to the top level.
// Depends on hufd_pkg and huffman_tree_byte_decoder.
`default_nettype none

module hufd_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire hufd_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped before acceptance");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("stalled result changed");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> out_data.last)
    else $error("final symbol of a chunk not marked last in its byte");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready straight after reset");

endmodule

bind huffman_tree_byte_decoder hufd_checker u_hufd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for huffman_tree_byte_decoder: tree loads, chunk starts and data
// bytes are driven through valid/ready and every decoded symbol is checked against a model.
// Depends on hufd_pkg and the decoder RTL only.
module testbench;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 32;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int LEAF_BASE        = 256;
  localparam logic [hufd_pkg::CMD_W-1:0]   CMD_UNUSED    = 2'd3;
  localparam logic [hufd_pkg::NODE_W-1:0]  ROOT          =
    hufd_pkg::NODE_W'(hufd_pkg::TREE_NODES - 1);
  localparam logic [hufd_pkg::CHILD_W-1:0] ROOT_POINTER  =
    hufd_pkg::CHILD_W'(LEAF_BASE + hufd_pkg::TREE_NODES - 1);
  localparam logic [hufd_pkg::CHILD_W-1:0] STRAY_POINTER =
    hufd_pkg::CHILD_W'(LEAF_BASE + hufd_pkg::TREE_NODES);

  class decode_checker;
    logic [hufd_pkg::ENTRY_W-1:0]     node_table [hufd_pkg::TREE_NODES];
    logic [hufd_pkg::NODE_W-1:0]      walk_node;
    logic [hufd_pkg::LENGTH_BITS-1:0] symbols_left;
    hufd_pkg::out_t                   pending_symbols [$];
    int                               errors;

    function new();
      foreach (node_table[i]) node_table[i] = '0;
      walk_node    = ROOT;
      symbols_left = '0;
      errors       = 0;
    endfunction

    function void note_transaction(hufd_pkg::in_t t);
      logic [hufd_pkg::ENTRY_W-1:0] entry;
      logic [hufd_pkg::CHILD_W-1:0] child;
      hufd_pkg::out_t               sym;
      hufd_pkg::out_t               burst [$];
      case (t.cmd)
        hufd_pkg::CMD_LOAD: begin
          if (t.node_index < hufd_pkg::TREE_NODES)
            node_table[t.node_index] = {t.child_one, t.child_zero};
        end
        hufd_pkg::CMD_START: begin
          symbols_left = t.expand_length[hufd_pkg::LENGTH_BITS-1:0];
          walk_node    = ROOT;
        end
        hufd_pkg::CMD_DATA: begin
          for (int b = 0; b < hufd_pkg::BYTE_W; b++) begin
            if (symbols_left == 0) break;
            entry = node_table[walk_node];
            child = t.data_byte[b] ? entry[hufd_pkg::ENTRY_W-1:hufd_pkg::CHILD_W]
                                   : entry[hufd_pkg::CHILD_W-1:0];
            if (child < LEAF_BASE) begin
              symbols_left  = symbols_left - 1'b1;
              sym.symbol    = child[hufd_pkg::BYTE_W-1:0];
              sym.last      = 1'b0;
              sym.done_res  = (symbols_left == 0);
              burst.push_back(sym);
              walk_node     = ROOT;
            end else if (child - LEAF_BASE < hufd_pkg::TREE_NODES) begin
              walk_node = hufd_pkg::NODE_W'(child - LEAF_BASE);
            end else begin
              walk_node = ROOT;
            end
          end
          foreach (burst[i]) begin
            sym      = burst[i];
            sym.last = (i == burst.size() - 1);
            pending_symbols.push_back(sym);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_symbol(hufd_pkg::out_t got);
      hufd_pkg::out_t want;
      if (pending_symbols.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected no symbol, got %0h last %0b done %0b",
                   got.symbol, got.last, got.done_res);
        return;
      end
      want = pending_symbols.pop_front();
      if (got.symbol !== want.symbol || got.last !== want.last ||
          got.done_res !== want.done_res) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected symbol %0h last %0b done %0b, got %0h %0b %0b",
                   want.symbol, want.last, want.done_res, got.symbol, got.last, got.done_res);
      end
    endfunction

    function int outstanding();
      return pending_symbols.size();
    endfunction

    function bit all_clear();
      return errors == 0 && pending_symbols.size() == 0;
    endfunction
  endclass

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  hufd_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  hufd_pkg::out_t out_data;

  int   send_idle   = 0;
  int   recv_stall  = 0;
  bit   pressure_go = 1'b0;
  logic long_hold   = 1'b0;
  bit   node_loaded [hufd_pkg::TREE_NODES];
  int   loaded_nodes [$];

  decode_checker sb = new();

  huffman_tree_byte_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_transaction(in_data);
      if (out_valid && out_ready) sb.check_symbol(out_data);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // one long receiver hold-off so the input side backs up
  initial begin
    wait (pressure_go);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  function automatic hufd_pkg::in_t random_item();
    hufd_pkg::in_t t;
    t.cmd           = hufd_pkg::CMD_W'($urandom_range(0, 3));
    t.node_index    = hufd_pkg::NODE_W'($urandom_range(0, 255));
    t.child_zero    = hufd_pkg::CHILD_W'($urandom_range(0, 511));
    t.child_one     = hufd_pkg::CHILD_W'($urandom_range(0, 511));
    t.expand_length = hufd_pkg::EXPLEN_W'($urandom_range(0, 24'hFFFFFF));
    t.data_byte     = hufd_pkg::BYTE_W'($urandom_range(0, 255));
    return t;
  endfunction

  // leaves, pointers to loaded nodes only, now and then a stray pointer
  function automatic logic [hufd_pkg::CHILD_W-1:0] pick_child();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 50 || loaded_nodes.size() == 0)
      return hufd_pkg::CHILD_W'($urandom_range(0, 255));
    if (r < 93) begin
      k = $urandom_range(0, loaded_nodes.size() - 1);
      return hufd_pkg::CHILD_W'(LEAF_BASE + loaded_nodes[k]);
    end
    return STRAY_POINTER;
  endfunction

  task automatic send_item(input hufd_pkg::in_t t);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load_node(input int idx, input logic [hufd_pkg::CHILD_W-1:0] c0,
                           input logic [hufd_pkg::CHILD_W-1:0] c1);
    hufd_pkg::in_t t;
    t            = random_item();
    t.cmd        = hufd_pkg::CMD_LOAD;
    t.node_index = hufd_pkg::NODE_W'(idx);
    t.child_zero = c0;
    t.child_one  = c1;
    send_item(t);
    if (idx < hufd_pkg::TREE_NODES && !node_loaded[idx]) begin
      node_loaded[idx] = 1'b1;
      loaded_nodes.push_back(idx);
    end
  endtask

  task automatic start_chunk(input logic [hufd_pkg::EXPLEN_W-1:0] len);
    hufd_pkg::in_t t;
    t               = random_item();
    t.cmd           = hufd_pkg::CMD_START;
    t.expand_length = len;
    send_item(t);
  endtask

  task automatic send_byte(input logic [hufd_pkg::BYTE_W-1:0] b);
    hufd_pkg::in_t t;
    t           = random_item();
    t.cmd       = hufd_pkg::CMD_DATA;
    t.data_byte = b;
    send_item(t);
  endtask

  task automatic send_unused();
    hufd_pkg::in_t t;
    t     = random_item();
    t.cmd = CMD_UNUSED;
    send_item(t);
  endtask

  task automatic run_phase(input int quota);
    int sent;
    int n;
    int r;
    logic [hufd_pkg::EXPLEN_W-1:0] len;
    sent = 0;
    while (sent < quota) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_unused();
        sent = sent + 1;
      end else if (r < 8) begin
        load_node(hufd_pkg::TREE_NODES, hufd_pkg::CHILD_W'($urandom_range(0, 511)),
                  hufd_pkg::CHILD_W'($urandom_range(0, 511)));
        sent = sent + 1;
      end else begin
        n = $urandom_range(0, 3);
        repeat (n) load_node($urandom_range(0, hufd_pkg::TREE_NODES - 1), pick_child(),
                             pick_child());
        r = $urandom_range(0, 99);
        if (r < 10) len = '0;
        else if (r < 75) len = hufd_pkg::EXPLEN_W'($urandom_range(1, 24));
        else if (r < 90) len = hufd_pkg::EXPLEN_W'($urandom_range(25, 200));
        else len = hufd_pkg::EXPLEN_W'($urandom_range(0, 24'hFFFFFF));
        start_chunk(len);
        sent = sent + n + 1;
        n = $urandom_range(1, 8);
        repeat (n) send_byte(hufd_pkg::BYTE_W'($urandom_range(0, 255)));
        sent = sent + n;
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_node(ROOT, 9'd0, 9'd255);
    send_byte(8'hFF);
    start_chunk('0);
    send_byte(8'hFF);
    start_chunk(24'd5);
    send_byte(8'hFF);
    send_byte(8'h00);
    load_node(0, 9'd7, ROOT_POINTER);
    load_node(1, STRAY_POINTER, hufd_pkg::CHILD_W'(LEAF_BASE));
    load_node(ROOT, hufd_pkg::CHILD_W'(LEAF_BASE + 1), 9'd200);
    load_node(hufd_pkg::TREE_NODES, 9'h1FF, 9'h1FF);
    send_unused();
    start_chunk(24'hFFFFFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h96);
    send_byte(8'h3C);
    start_chunk(24'd3);
    send_byte(8'hFF);
    send_byte(8'hFF);
    start_chunk(24'd1);
    send_byte(8'h01);

    send_idle = 0;
    recv_stall <= 0;
    run_phase(60);
    send_idle = 47;
    run_phase(60);
    send_idle = 0;
    recv_stall <= 47;
    run_phase(60);
    send_idle = 25;
    recv_stall <= 25;
    run_phase(60);
    send_idle = 0;
    recv_stall <= 0;
    pressure_go = 1'b1;
    run_phase(40);

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.all_clear()) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
